// ===== hw/rtl/ptba_pkg.sv =====
// ============================================================================
// Token bucket admission package
// Shared widths, codes and the front-to-back control record.
// ============================================================================
`default_nettype none

package ptba_pkg;

    localparam int DEF_BURST_FLOOR      = 20;
    localparam int DEF_TICKS_PER_SECOND = 1000000;

    localparam int NOW_W       = 48;
    localparam int DEPTH_W     = 16;
    localparam int RATE_W      = 16;
    localparam int BURST_W     = 17;  // holds twice the largest rate
    localparam int LEASE_W     = 8;
    localparam int LEVEL_W     = 2;
    localparam int CAUSE_W     = 3;
    localparam int SHED_W      = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEASE_W-1:0] DEFAULT_LEASE   = LEASE_W'(3);
    localparam logic [LEASE_W-1:0] RESET_LEASE     = LEASE_W'(3);
    localparam logic [DEPTH_W-1:0] RESET_THRESHOLD = DEPTH_W'(256);

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_REPORT  = 1'b1;

    localparam logic [CAUSE_W-1:0] CAUSE_EMERGENCY     = CAUSE_W'(0);
    localparam logic [CAUSE_W-1:0] CAUSE_HIGH_PRIORITY = CAUSE_W'(1);
    localparam logic [CAUSE_W-1:0] CAUSE_MT_ACCESS     = CAUSE_W'(2);
    localparam logic [CAUSE_W-1:0] CAUSE_VOICE_CALL    = CAUSE_W'(6);

    localparam logic [LEVEL_W-1:0] LEVEL_NONE = LEVEL_W'(0);
    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = LEVEL_W'(1);
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH = LEVEL_W'(2);

    typedef enum logic [2:0] {
        DEC_ADMIT         = 3'd0,
        DEC_PASS          = 3'd1,
        DEC_RATE_SHED     = 3'd2,
        DEC_OVERLOAD_SHED = 3'd3,
        DEC_REPORT        = 3'd4
    } decision_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE    = 3'd0,
        CFG_RATE      = 3'd1,
        CFG_BURST     = 3'd2,
        CFG_LEASE     = 3'd3,
        CFG_THRESHOLD = 3'd4
    } cfg_index_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic                ordinary;  // request that goes through bucket and overload checks
        logic                take;      // takes a token from the bucket
        logic                fill_cap;  // bucket refills to its cap first
        logic                fill_add;  // bucket refills by the carried amount first
        logic                overload;  // shed for overload unless shed for lack of a token
        decision_t           fixed_dec; // decision when not ordinary
        logic [LEVEL_W-1:0]  level;
    } ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptba_queue.sv =====
// ============================================================================
// Token bucket admission queue
// Small FIFO between the classifying front and the bucket back end.
// ============================================================================
`default_nettype none

module ptba_queue
    import ptba_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ptba_front.sv =====
// ============================================================================
// Token bucket admission front end
// Accepts items, tracks congestion reports and bucket time, works out the
// level and class of each item, and precomputes the bucket refill amount.
// ============================================================================
`default_nettype none

module ptba_front
    import ptba_pkg::*;
#(
    parameter int CAP_W     = BURST_W + $clog2(DEF_TICKS_PER_SECOND + 1),
    parameter int LEASE_T_W = LEASE_W + $clog2(DEF_TICKS_PER_SECOND + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 operation,
    input  wire logic [NOW_W-1:0]     now_us,
    input  wire logic [CAUSE_W-1:0]   cause,
    input  wire logic                 cause_present,
    input  wire logic [LEVEL_W-1:0]   net_level,
    input  wire logic [DEPTH_W-1:0]   queue_depth,
    input  wire logic                 enable,
    input  wire logic [RATE_W-1:0]    rate,
    input  wire logic [DEPTH_W-1:0]   depth_threshold,
    input  wire logic [CAP_W-1:0]     cap,
    input  wire logic [LEASE_T_W-1:0] lease_ticks,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output ctl_t                      q_ctl,
    output logic [CAP_W-1:0]          q_add
);

    localparam int PROD_W = CAP_W + RATE_W;

    // Congestion report and bucket time tracking
    logic                 cvalid_reg;
    logic [NOW_W-1:0]     ctime_reg;
    logic [DEPTH_W-1:0]   cdepth_reg;
    logic                 bvalid_reg;
    logic [NOW_W-1:0]     btime_reg;

    // Pipeline stages
    logic                 s1_valid_reg, s1_valid_next;
    ctl_t                 s1_ctl_reg;
    logic [CAP_W-1:0]     s1_el_reg;
    logic                 s2_valid_reg, s2_valid_next;
    ctl_t                 s2_ctl_reg;
    logic [PROD_W-1:0]    s2_prod_reg;

    logic                 in_fire, s1_move, s2_free;
    logic                 is_report, prio_cause, mt_cause, voice_cause;
    logic [NOW_W:0]       cgap, bgap;
    logic                 stale, fresh, later, sat;
    logic [DEPTH_W-1:0]   depth_sel;
    logic [LEVEL_W-1:0]   report_level, max_level, level_a;
    logic                 keep;
    ctl_t                 ctl_a;

    assign s2_free = !s2_valid_reg || q_ready;
    assign s1_move = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        is_report   = (operation == OP_REPORT);
        prio_cause  = cause_present && (cause inside {CAUSE_EMERGENCY, CAUSE_HIGH_PRIORITY});
        mt_cause    = cause_present && (cause == CAUSE_MT_ACCESS);
        voice_cause = cause_present && (cause == CAUSE_VOICE_CALL);

        // A report counts against its own depth and is always fresh
        cgap      = {1'b0, now_us} - {1'b0, ctime_reg};
        stale     = !cgap[NOW_W] && (cgap[NOW_W-1:0] >= NOW_W'(lease_ticks));
        fresh     = is_report || (cvalid_reg && !stale);
        depth_sel = is_report ? queue_depth : cdepth_reg;
        if (!fresh)
        begin
            report_level = LEVEL_NONE;
        end
        else if ({1'b0, depth_sel} >= {depth_threshold, 1'b0})
        begin
            report_level = LEVEL_HIGH;
        end
        else
        begin
            report_level = LEVEL_LOW;
        end
        max_level = (net_level > report_level) ? net_level : report_level;
        if (!enable)
        begin
            level_a = LEVEL_NONE;
        end
        else if (max_level > LEVEL_HIGH)
        begin
            level_a = LEVEL_HIGH;
        end
        else
        begin
            level_a = max_level;
        end
        keep = mt_cause || ((level_a == LEVEL_LOW) && voice_cause);

        bgap  = {1'b0, now_us} - {1'b0, btime_reg};
        later = !bgap[NOW_W] && (bgap[NOW_W-1:0] != '0);
        sat   = bgap[NOW_W-1:0] >= NOW_W'(cap);

        ctl_a.ordinary  = !is_report && enable && !prio_cause;
        ctl_a.take      = ctl_a.ordinary && (rate != '0);
        ctl_a.fill_cap  = ctl_a.take && (!bvalid_reg || (later && sat));
        ctl_a.fill_add  = ctl_a.take && bvalid_reg && later && !sat;
        ctl_a.overload  = (level_a != LEVEL_NONE) && !keep;
        ctl_a.fixed_dec = is_report ? DEC_REPORT : DEC_PASS;
        ctl_a.level     = level_a;

        s1_valid_next = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        s2_valid_next = s1_move ? 1'b1 : (s2_free ? 1'b0 : s2_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg   <= 1'b0;
            ctime_reg    <= '0;
            cdepth_reg   <= '0;
            bvalid_reg   <= 1'b0;
            btime_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (in_fire && is_report)
            begin
                cvalid_reg <= 1'b1;
                ctime_reg  <= now_us;
                cdepth_reg <= queue_depth;
            end
            // Bucket time follows every token take that moves time forward
            if (in_fire && ctl_a.take && (!bvalid_reg || later))
            begin
                bvalid_reg <= 1'b1;
                btime_reg  <= now_us;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ctl_reg <= ctl_a;
            s1_el_reg  <= bgap[CAP_W-1:0];
        end
        if (s1_move)
        begin
            s2_ctl_reg  <= s1_ctl_reg;
            s2_prod_reg <= PROD_W'(s1_el_reg) * PROD_W'(rate);
        end
    end

    // Clamp the refill amount to the cap on the way into the queue
    assign q_valid = s2_valid_reg;
    assign q_ctl   = s2_ctl_reg;
    assign q_add   = (s2_prod_reg >= PROD_W'(cap)) ? cap : s2_prod_reg[CAP_W-1:0];

    a_fill_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_ctl_reg.fill_cap && s1_ctl_reg.fill_add))
        else $error("bucket refill marked both to cap and by amount");

    a_take_only_ordinary : assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_ctl_reg.take) |-> s2_ctl_reg.ordinary)
        else $error("token take on a non-ordinary item");

endmodule

`default_nettype wire

// ===== hw/rtl/ptba_back.sv =====
// ============================================================================
// Token bucket admission back end
// Applies refill and token take to the bucket, settles the decision, counts
// sheds and holds the result beat.
// ============================================================================
`default_nettype none

module ptba_back
    import ptba_pkg::*;
#(
    parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND,
    parameter int CAP_W            = BURST_W + $clog2(DEF_TICKS_PER_SECOND + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_pop,
    input  wire ctl_t               q_ctl,
    input  wire logic [CAP_W-1:0]   q_add,
    input  wire logic [CAP_W-1:0]   cap,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              decision,
    output logic [LEVEL_W-1:0]      level,
    output logic [SHED_W-1:0]       shed_count
);

    localparam logic [CAP_W-1:0] UNIT = CAP_W'(TICKS_PER_SECOND);

    logic               out_valid_reg;
    decision_t          decision_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [CAP_W-1:0]   bucket_reg, bucket_next;
    logic [SHED_W-1:0]  shed_reg, shed_next;

    logic [CAP_W:0]     sum;
    logic [CAP_W-1:0]   filled;
    logic               has_token;
    decision_t          dec_next;

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        sum = {1'b0, bucket_reg} + {1'b0, q_add};
        if (q_ctl.fill_cap)
        begin
            filled = cap;
        end
        else if (q_ctl.fill_add)
        begin
            filled = (sum >= {1'b0, cap}) ? cap : sum[CAP_W-1:0];
        end
        else
        begin
            filled = bucket_reg;
        end
        has_token = (filled >= UNIT);

        if (!q_ctl.ordinary)
        begin
            dec_next = q_ctl.fixed_dec;
        end
        else if (q_ctl.take && !has_token)
        begin
            dec_next = DEC_RATE_SHED;
        end
        else if (q_ctl.overload)
        begin
            dec_next = DEC_OVERLOAD_SHED;
        end
        else
        begin
            dec_next = DEC_ADMIT;
        end

        bucket_next = bucket_reg;
        shed_next   = shed_reg;
        if (q_pop)
        begin
            if (q_ctl.take)
            begin
                bucket_next = has_token ? filled - UNIT : filled;
            end
            if ((dec_next == DEC_RATE_SHED) || (dec_next == DEC_OVERLOAD_SHED))
            begin
                shed_next = shed_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            bucket_reg    <= '0;
            shed_reg      <= '0;
        end
        else
        begin
            bucket_reg <= bucket_next;
            shed_reg   <= shed_next;
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            decision_reg <= dec_next;
            level_reg    <= q_ctl.level;
        end
    end

    // Shed total only moves on a pop, so it matches the held beat
    assign out_valid  = out_valid_reg;
    assign decision   = decision_reg;
    assign level      = level_reg;
    assign shed_count = shed_reg;

    a_shed_step : assert property (@(posedge clk) disable iff (!rst_n)
        (shed_reg == $past(shed_reg)) || (shed_reg == $past(shed_reg) + 32'd1))
        else $error("shed count jumped by more than one");

    a_bucket_untouched : assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_ctl.take) |=> (bucket_reg == $past(bucket_reg)))
        else $error("bucket changed without a token take");

    a_fixed_class : assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_ctl.ordinary) |->
            ((q_ctl.fixed_dec == DEC_PASS) || (q_ctl.fixed_dec == DEC_REPORT)))
        else $error("non-ordinary item carries a bucket decision");

endmodule

`default_nettype wire

// ===== hw/rtl/priority_token_bucket_admission.sv =====
// ============================================================================
// Priority token bucket admission gate
// Per-link admission control with congestion reports, priority bypass,
// a micro-token rate bucket and overload shedding.
// ============================================================================
// Takes one item per clock while in_ready is high and returns one result beat
// per item, in order, once it has passed two front stages (classification and
// level, then the refill multiply), the queue and the result register. The
// rate is set by the back end's bucket loop, one refill add, cap compare and
// token subtract per cycle while the output is not stalled. The front keeps
// congestion report and bucket time state; the back keeps the bucket level and
// the shed total. Configuration writes take effect at once; the user must make
// them only while no item is in flight, which the block does not enforce.
`default_nettype none

module priority_token_bucket_admission
    import ptba_pkg::*;
#(
    parameter int BURST_FLOOR      = DEF_BURST_FLOOR,
    parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   operation,
    input  wire logic [NOW_W-1:0]       now_us,
    input  wire logic [CAUSE_W-1:0]     cause,
    input  wire logic                   cause_present,
    input  wire logic [LEVEL_W-1:0]     net_level,
    input  wire logic [DEPTH_W-1:0]     queue_depth,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [2:0]                  decision,
    output logic [LEVEL_W-1:0]          level,
    output logic [SHED_W-1:0]           shed_count,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int TICK_W    = $clog2(TICKS_PER_SECOND + 1);
    localparam int CAP_W     = BURST_W + TICK_W;
    localparam int LEASE_T_W = LEASE_W + TICK_W;
    localparam int Q_W       = $bits(ctl_t) + CAP_W;

    logic                 enable_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic [RATE_W-1:0]    burst_reg;
    logic [LEASE_W-1:0]   lease_reg;
    logic [DEPTH_W-1:0]   thresh_reg;

    logic [BURST_W-1:0]   burst_sel, burst_eff;
    logic [LEASE_W-1:0]   lease_eff;
    logic [CAP_W-1:0]     cap;
    logic [LEASE_T_W-1:0] lease_ticks;

    logic                 f_valid, f_ready;
    ctl_t                 f_ctl, b_ctl;
    logic [CAP_W-1:0]     f_add, b_add;
    logic [Q_W-1:0]       push_data, pop_data;
    logic                 b_valid, b_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            rate_reg   <= '0;
            burst_reg  <= '0;
            lease_reg  <= RESET_LEASE;
            thresh_reg <= RESET_THRESHOLD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ENABLE:    enable_reg <= cfg_data[0];
                CFG_RATE:      rate_reg   <= cfg_data[RATE_W-1:0];
                CFG_BURST:     burst_reg  <= cfg_data[RATE_W-1:0];
                CFG_LEASE:     lease_reg  <= cfg_data[LEASE_W-1:0];
                CFG_THRESHOLD: thresh_reg <= cfg_data[DEPTH_W-1:0];
                default:       ;
            endcase
        end
    end

    // Zero burst means twice the rate; never below the floor
    always_comb
    begin
        burst_sel   = (burst_reg != '0) ? {1'b0, burst_reg} : {rate_reg, 1'b0};
        burst_eff   = (burst_sel < BURST_W'(BURST_FLOOR)) ? BURST_W'(BURST_FLOOR) : burst_sel;
        cap         = CAP_W'(burst_eff) * CAP_W'(TICKS_PER_SECOND);
        lease_eff   = (lease_reg != '0) ? lease_reg : DEFAULT_LEASE;
        lease_ticks = LEASE_T_W'(lease_eff) * LEASE_T_W'(TICKS_PER_SECOND);
    end

    ptba_front #(
        .CAP_W            (CAP_W),
        .LEASE_T_W        (LEASE_T_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .now_us          (now_us),
        .cause           (cause),
        .cause_present   (cause_present),
        .net_level       (net_level),
        .queue_depth     (queue_depth),
        .enable          (enable_reg),
        .rate            (rate_reg),
        .depth_threshold (thresh_reg),
        .cap             (cap),
        .lease_ticks     (lease_ticks),
        .q_valid         (f_valid),
        .q_ready         (f_ready),
        .q_ctl           (f_ctl),
        .q_add           (f_add)
    );

    assign push_data = {f_ctl, f_add};

    ptba_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (push_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_pop),
        .pop_data   (pop_data)
    );

    assign {b_ctl, b_add} = pop_data;

    ptba_back #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .CAP_W            (CAP_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (b_valid),
        .q_pop      (b_pop),
        .q_ctl      (b_ctl),
        .q_add      (b_add),
        .cap        (cap),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .decision   (decision),
        .level      (level),
        .shed_count (shed_count)
    );

endmodule

`default_nettype wire
